### design/ntcat_pkg.sv
`timescale 1ns / 1ps

package ntcat_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int TEMP_W        = 17;
  localparam int STATUS_W      = 2;
  localparam int TABLE_ENTRIES = 231;
  localparam int FRACTION_BITS = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int DIV_CNT_W     = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;
  localparam int TEMP_START_OFS = 80;

  localparam logic [IDX_W-1:0]     FIRST_IDX = '0;
  localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(FRACTION_BITS - 1);

  localparam logic [STATUS_W-1:0] ST_INTERP = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOW    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HIGH   = 2'd2;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -17'sd20480;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd38400;

  localparam logic [SAMPLE_W-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    12'h003, 12'h003, 12'h004, 12'h004, 12'h005, 12'h005, 12'h006, 12'h006,
    12'h007, 12'h008, 12'h008, 12'h009, 12'h00A, 12'h00B, 12'h00C, 12'h00D,
    12'h00F, 12'h010, 12'h011, 12'h013, 12'h015, 12'h017, 12'h019, 12'h01B,
    12'h01D, 12'h020, 12'h022, 12'h025, 12'h028, 12'h02C, 12'h02F, 12'h033,
    12'h037, 12'h03B, 12'h040, 12'h045, 12'h04A, 12'h050, 12'h056, 12'h05D,
    12'h063, 12'h06B, 12'h072, 12'h07B, 12'h083, 12'h08C, 12'h096, 12'h0A0,
    12'h0AB, 12'h0B7, 12'h0C3, 12'h0D0, 12'h0DD, 12'h0EB, 12'h0FA, 12'h109,
    12'h11A, 12'h12B, 12'h13D, 12'h14F, 12'h163, 12'h177, 12'h18D, 12'h1A3,
    12'h1BA, 12'h1D2, 12'h1EB, 12'h205, 12'h220, 12'h23B, 12'h258, 12'h276,
    12'h295, 12'h2B4, 12'h2D5, 12'h2F6, 12'h319, 12'h33C, 12'h360, 12'h385,
    12'h3AB, 12'h3D2, 12'h3F9, 12'h421, 12'h44A, 12'h474, 12'h49E, 12'h4C9,
    12'h4F5, 12'h521, 12'h54D, 12'h57A, 12'h5A8, 12'h5D5, 12'h603, 12'h631,
    12'h660, 12'h68E, 12'h6BD, 12'h6EB, 12'h71A, 12'h748, 12'h776, 12'h7A4,
    12'h7D2, 12'h800, 12'h82D, 12'h85A, 12'h887, 12'h8B3, 12'h8DF, 12'h90A,
    12'h935, 12'h95F, 12'h989, 12'h9B2, 12'h9DA, 12'hA02, 12'hA29, 12'hA4F,
    12'hA75, 12'hA9A, 12'hABE, 12'hAE2, 12'hB05, 12'hB27, 12'hB48, 12'hB69,
    12'hB89, 12'hBA8, 12'hBC6, 12'hBE4, 12'hC01, 12'hC1D, 12'hC39, 12'hC54,
    12'hC6E, 12'hC88, 12'hCA1, 12'hCB9, 12'hCD0, 12'hCE7, 12'hCFE, 12'hD13,
    12'hD28, 12'hD3D, 12'hD51, 12'hD64, 12'hD77, 12'hD89, 12'hD9B, 12'hDAC,
    12'hDBD, 12'hDCD, 12'hDDD, 12'hDEC, 12'hDFB, 12'hE0A, 12'hE18, 12'hE25,
    12'hE32, 12'hE3F, 12'hE4B, 12'hE58, 12'hE63, 12'hE6E, 12'hE79, 12'hE84,
    12'hE8E, 12'hE99, 12'hEA2, 12'hEAC, 12'hEB5, 12'hEBE, 12'hEC6, 12'hECF,
    12'hED7, 12'hEDF, 12'hEE6, 12'hEEE, 12'hEF5, 12'hEFC, 12'hF03, 12'hF09,
    12'hF10, 12'hF16, 12'hF1C, 12'hF22, 12'hF27, 12'hF2D, 12'hF32, 12'hF37,
    12'hF3C, 12'hF41, 12'hF46, 12'hF4B, 12'hF4F, 12'hF53, 12'hF58, 12'hF5C,
    12'hF60, 12'hF64, 12'hF67, 12'hF6B, 12'hF6F, 12'hF72, 12'hF75, 12'hF79,
    12'hF7C, 12'hF7F, 12'hF82, 12'hF85, 12'hF88, 12'hF8B, 12'hF8D, 12'hF90,
    12'hF92, 12'hF95, 12'hF97, 12'hF9A, 12'hF9C, 12'hF9E, 12'hFA0, 12'hFA2,
    12'hFA5, 12'hFA7, 12'hFA9, 12'hFAB, 12'hFAC, 12'hFAE, 12'hFB0
  };

  typedef enum logic [1:0] {
    RES_LOW    = 2'd0,
    RES_HIGH   = 2'd1,
    RES_HIT    = 2'd2,
    RES_INTERP = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     step;
    logic     span;
    logic     div;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic at_low;
    logic at_high;
    logic hit;
    logic adjacent;
  } sts_t;

  function automatic logic [SAMPLE_W-1:0] rom_code(input logic [IDX_W-1:0] idx);
    if (idx <= LAST_IDX) begin
      return NTC_ROM[idx];
    end
    return NTC_ROM[TABLE_ENTRIES-1];
  endfunction

  function automatic logic signed [TEMP_W-1:0] degree_q(input logic [IDX_W-1:0] idx);
    logic [TEMP_W-1:0] deg;
    deg = {{(TEMP_W-IDX_W){1'b0}}, idx} - TEMP_W'(TEMP_START_OFS);
    return signed'(deg << FRACTION_BITS);
  endfunction

endpackage

### design/ntcat_if.sv
`timescale 1ns / 1ps

interface ntcat_sample_if;
  import ntcat_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface ntcat_result_if;
  import ntcat_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [TEMP_W-1:0]   temperature_q8;
  logic        [STATUS_W-1:0] range_status;
  modport source (output valid, output temperature_q8, output range_status, input ready);
  modport sink (input valid, input temperature_q8, input range_status, output ready);
endinterface

### design/ntcat_ctrl.sv
`timescale 1ns / 1ps

module ntcat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ntcat_pkg::sts_t sts,
  output ntcat_pkg::cmd_t cmd
);
  import ntcat_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RANGE  = 6'b000010,
    S_SEARCH = 6'b000100,
    S_SPAN   = 6'b001000,
    S_DIV    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        if (sts.at_low || sts.at_high) begin
          if (out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = sts.at_low ? RES_LOW : RES_HIGH;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.adjacent) begin
          state_next = S_SPAN;
        end else if (sts.hit) begin
          if (out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_HIT;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SPAN: begin
        cmd.span   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_INTERP;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.span) begin
        cnt <= '0;
      end else if (cmd.div) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/ntcat_dp.sv
`timescale 1ns / 1ps

module ntcat_dp (
  input  logic                                clk,
  input  ntcat_pkg::cmd_t                     cmd,
  output ntcat_pkg::sts_t                     sts,
  input  logic        [ntcat_pkg::SAMPLE_W-1:0] adc_sample,
  output logic signed [ntcat_pkg::TEMP_W-1:0]   temperature_q8,
  output logic        [ntcat_pkg::STATUS_W-1:0] range_status
);
  import ntcat_pkg::*;

  logic [SAMPLE_W-1:0]      sample;
  logic [IDX_W-1:0]         lo_idx;
  logic [IDX_W-1:0]         hi_idx;
  logic [IDX_W-1:0]         mid;
  logic [SAMPLE_W-1:0]      code;
  logic [SAMPLE_W-1:0]      span;
  logic [SAMPLE_W-1:0]      rem;
  logic [FRACTION_BITS-1:0] quot;
  logic [SAMPLE_W:0]        rem_shift;
  logic                     take;
  logic [SAMPLE_W-1:0]      lo_code;
  logic [SAMPLE_W-1:0]      hi_code;

  assign mid       = IDX_W'(({1'b0, lo_idx} + {1'b0, hi_idx}) >> 1);
  assign code      = rom_code(mid);
  assign lo_code   = rom_code(lo_idx);
  assign hi_code   = rom_code(hi_idx);
  assign rem_shift = {rem, 1'b0};
  assign take      = (rem_shift >= {1'b0, span});

  assign sts.at_low   = (sample <= rom_code(FIRST_IDX));
  assign sts.at_high  = (sample >= rom_code(LAST_IDX));
  assign sts.hit      = (code == sample);
  assign sts.adjacent = ((hi_idx - lo_idx) == IDX_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= adc_sample;
      lo_idx <= FIRST_IDX;
      hi_idx <= LAST_IDX;
    end
    if (cmd.step) begin
      if (code > sample) begin
        hi_idx <= mid;
      end else begin
        lo_idx <= mid;
      end
    end
    if (cmd.span) begin
      span <= hi_code - lo_code;
      rem  <= sample - lo_code;
      quot <= '0;
    end
    if (cmd.div) begin
      if (take) begin
        rem <= SAMPLE_W'(rem_shift - {1'b0, span});
      end else begin
        rem <= SAMPLE_W'(rem_shift);
      end
      quot <= {quot[FRACTION_BITS-2:0], take};
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_LOW: begin
          temperature_q8 <= degree_q(FIRST_IDX);
          range_status   <= ST_LOW;
        end
        RES_HIGH: begin
          temperature_q8 <= degree_q(LAST_IDX);
          range_status   <= ST_HIGH;
        end
        RES_HIT: begin
          temperature_q8 <= degree_q(mid);
          range_status   <= ST_INTERP;
        end
        default: begin
          temperature_q8 <= degree_q(lo_idx) + signed'({{(TEMP_W-FRACTION_BITS){1'b0}}, quot});
          range_status   <= ST_INTERP;
        end
      endcase
    end
  end

endmodule

### design/ntc_adc_to_temperature.sv
`timescale 1ns / 1ps

// Converts one 12-bit NTC divider reading per beat into temperature in degrees C as signed
// fixed point with 8 fractional bits, plus a range status (0 in range, 1 clamped at -80 C,
// 2 clamped at 150 C). A clamped sample is done after the end checks and an exact table hit
// within the search; an interpolated one goes through, in order: accepting it, the end checks,
// 7 or 8 binary-search steps with one table read per cycle, a check that the interval has
// closed, loading the span, 8 restoring-divide steps (one fraction bit each), and writing
// the output register. One sample is in work at a time; the next one is accepted as soon
// as the result sits in the output register.
module ntc_adc_to_temperature (
  input logic            clk,
  input logic            rst,
  ntcat_sample_if.sink   sample,
  ntcat_result_if.source result
);
  import ntcat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ntcat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ntcat_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .adc_sample     (sample.adc_sample),
    .temperature_q8 (result.temperature_q8),
    .range_status   (result.range_status)
  );

  a_low_value: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.range_status == ST_LOW |-> result.temperature_q8 == TEMP_MIN)
    else $error("low clamp with wrong temperature");

  a_high_value: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.range_status == ST_HIGH |-> result.temperature_q8 == TEMP_MAX)
    else $error("high clamp with wrong temperature");

  a_span_adjacent: assert property (@(posedge clk) disable iff (rst)
    cmd.span |-> sts.adjacent && !sts.at_low && !sts.at_high)
    else $error("span loaded before search converged");

  a_no_accept_in_work: assert property (@(posedge clk) disable iff (rst)
    cmd.step || cmd.div |-> !sample.ready)
    else $error("sample accepted while one is in work");

endmodule
